[hw/rtl/sst_pkg.sv]
`timescale 1ns / 1ps

package sst_pkg;

   // default number of key slots
   localparam int unsigned CAPACITY_DEF = 64;

   // field widths fixed by the item layout
   localparam int unsigned KEY_W      = 32;
   localparam int unsigned OP_W       = 2;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned POS_W      = 6;
   localparam int unsigned ENT_W      = 7;
   localparam int unsigned REQ_DATA_W = 64;
   localparam int unsigned RSP_DATA_W = 16;

   // request operations
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic                load;          // take in a request, start search on key
      logic                srch_init;     // restart search (lo = 0, hi = count)
      logic                use_new;       // search / place target is new_key
      logic                srch_cmp;      // narrow the window on the read key
      logic                save_pos;      // pos = search result
      logic                save_q;        // q = insertion slot once old key is gone
      logic                set_pos_q;     // pos = q
      logic                up_init;       // cursor = count, ready to open a gap
      logic                dn_init;       // cursor = pos, ready to close a gap
      logic                shift_up;      // one step of moving keys up
      logic                shift_dn;      // one step of moving keys down
      logic                place;         // write target key at pos
      logic                cnt_inc;
      logic                cnt_dec;
      logic                rsp_load;      // capture the result item
      logic [STATUS_W-1:0] code;          // status for the result item
   } sst_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic            srch_done;         // window empty, lo is the lower bound
      logic            hit;               // key at lower bound equals target
      logic            full;              // no free slot
      logic            up_more;           // a key is still to be moved up
      logic            dn_more;           // a key is still to be moved down
      logic [OP_W-1:0] op;
   } sst_stat_type;

endpackage

[hw/rtl/sst_dpath.sv]
`timescale 1ns / 1ps

module sst_dpath #(
   parameter int unsigned CAPACITY = sst_pkg::CAPACITY_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [sst_pkg::OP_W-1:0]           req_op,
   input  logic signed [sst_pkg::KEY_W-1:0]   req_key,
   input  logic signed [sst_pkg::KEY_W-1:0]   req_new_key,
   input  sst_pkg::sst_cmd_type               cmd,
   output sst_pkg::sst_stat_type              stat,
   output logic [sst_pkg::STATUS_W-1:0]       rsp_status,
   output logic [sst_pkg::POS_W-1:0]          rsp_position,
   output logic [sst_pkg::ENT_W-1:0]          rsp_entries
);

   localparam int unsigned IDX_W = $clog2(CAPACITY);
   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam int unsigned KW    = sst_pkg::KEY_W;
   localparam int unsigned PW    = sst_pkg::POS_W;
   localparam int unsigned EW    = sst_pkg::ENT_W;

   // key store, one write and one registered read per cycle
   logic [KW-1:0] mem [CAPACITY];

   logic signed [KW-1:0]       key_ff, key_in;
   logic signed [KW-1:0]       nkey_ff, nkey_in;
   logic [sst_pkg::OP_W-1:0]   op_ff, op_in;
   logic [CNT_W-1:0]           lo_ff, lo_in;
   logic [CNT_W-1:0]           hi_ff, hi_in;
   logic                       hit_ff, hit_in;
   logic [CNT_W-1:0]           pos_ff, pos_in;
   logic [CNT_W-1:0]           q_ff, q_in;
   logic [CNT_W-1:0]           cur_ff, cur_in;
   logic [IDX_W-1:0]           wa_ff, wa_in;
   logic                       pend_ff, pend_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [KW-1:0]              rdata_ff;
   logic [sst_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [PW-1:0]              rsp_pos_ff, rsp_pos_in;
   logic [EW-1:0]              rsp_ent_ff, rsp_ent_in;

   logic [CNT_W:0]             mid_sum;
   logic [CNT_W-1:0]           mid;
   logic [CNT_W-1:0]           cur_dec;
   logic [CNT_W-1:0]           cur_inc;
   logic signed [KW-1:0]       tgt;
   logic                       less;
   logic [IDX_W-1:0]           rd_addr;
   logic                       mem_we;
   logic [IDX_W-1:0]           mem_wa;
   logic [KW-1:0]              mem_wd;
   logic [CNT_W+PW-1:0]        pos_wide;
   logic [CNT_W+EW-1:0]        cnt_wide;

   // search window midpoint, cursor neighbours, compare
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[CNT_W:1];
   assign cur_dec = cur_ff - 1'b1;
   assign cur_inc = cur_ff + 1'b1;
   assign tgt     = cmd.use_new ? nkey_ff : key_ff;
   assign less    = $signed(rdata_ff) < tgt;

   // status to the controller
   assign stat.srch_done = (lo_ff == hi_ff);
   assign stat.hit       = hit_ff;
   assign stat.full      = (cnt_ff == CNT_W'(CAPACITY));
   assign stat.up_more   = (cur_ff > pos_ff);
   assign stat.dn_more   = (cur_inc < cnt_ff);
   assign stat.op        = op_ff;

   // read address: shift source or search probe
   always_comb begin
      priority if (cmd.shift_up) begin
         rd_addr = cur_dec[IDX_W-1:0];
      end else if (cmd.shift_dn) begin
         rd_addr = cur_inc[IDX_W-1:0];
      end else begin
         rd_addr = mid[IDX_W-1:0];
      end
   end

   // write port: pending shift move or the new key
   always_comb begin
      mem_we = cmd.place || ((cmd.shift_up || cmd.shift_dn) && pend_ff);
      mem_wa = cmd.place ? pos_ff[IDX_W-1:0] : wa_ff;
      mem_wd = cmd.place ? tgt : rdata_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rdata_ff <= mem[rd_addr];
   end

   // result fields, masked to their widths
   assign pos_wide = {{PW{1'b0}}, pos_ff};
   assign cnt_wide = {{EW{1'b0}}, cnt_ff};

   // next-state logic of the datapath registers
   always_comb begin
      key_in        = key_ff;
      nkey_in       = nkey_ff;
      op_in         = op_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      hit_in        = hit_ff;
      pos_in        = pos_ff;
      q_in          = q_ff;
      cur_in        = cur_ff;
      wa_in         = wa_ff;
      pend_in       = pend_ff;
      cnt_in        = cnt_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_ent_in    = rsp_ent_ff;

      if (cmd.load) begin
         key_in  = req_key;
         nkey_in = req_new_key;
         op_in   = req_op;
      end
      if (cmd.load || cmd.srch_init) begin
         lo_in  = '0;
         hi_in  = cnt_ff;
         hit_in = 1'b0;
      end
      // lower bound step; remember equality each time hi moves
      if (cmd.srch_cmp) begin
         if (less) begin
            lo_in = mid + 1'b1;
         end else begin
            hi_in  = mid;
            hit_in = (rdata_ff == tgt);
         end
      end
      if (cmd.save_pos) begin
         pos_in = lo_ff;
      end
      // the old key sits below the new slot: that slot drops by one
      if (cmd.save_q) begin
         q_in = (lo_ff > pos_ff) ? lo_ff - 1'b1 : lo_ff;
      end
      if (cmd.set_pos_q) begin
         pos_in = q_ff;
      end
      if (cmd.up_init) begin
         cur_in  = cnt_ff;
         pend_in = 1'b0;
      end
      if (cmd.dn_init) begin
         cur_in  = pos_ff;
         pend_in = 1'b0;
      end
      // move one key a cycle: read the source now, write it next cycle
      if (cmd.shift_up) begin
         if (stat.up_more) begin
            wa_in   = cur_ff[IDX_W-1:0];
            cur_in  = cur_dec;
            pend_in = 1'b1;
         end else begin
            pend_in = 1'b0;
         end
      end
      if (cmd.shift_dn) begin
         if (stat.dn_more) begin
            wa_in   = cur_ff[IDX_W-1:0];
            cur_in  = cur_inc;
            pend_in = 1'b1;
         end else begin
            pend_in = 1'b0;
         end
      end
      if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.cnt_dec) begin
         cnt_in = cnt_ff - 1'b1;
      end
      if (cmd.rsp_load) begin
         rsp_status_in = cmd.code;
         rsp_pos_in    = (cmd.code == sst_pkg::ST_OK) ? pos_wide[PW-1:0] : '0;
         rsp_ent_in    = cnt_wide[EW-1:0];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         pend_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         pend_ff <= pend_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      nkey_ff       <= nkey_in;
      op_ff         <= op_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      hit_ff        <= hit_in;
      pos_ff        <= pos_in;
      q_ff          <= q_in;
      cur_ff        <= cur_in;
      wa_ff         <= wa_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_ent_ff    <= rsp_ent_in;
   end

   assign rsp_status   = rsp_status_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_entries  = rsp_ent_ff;

endmodule

[hw/rtl/sst_ctrl.sv]
`timescale 1ns / 1ps

module sst_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  sst_pkg::sst_stat_type stat,
   output sst_pkg::sst_cmd_type  cmd
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_SRCH    = 4'd1;
   localparam logic [3:0] S_CMP     = 4'd2;
   localparam logic [3:0] S_DN_INIT = 4'd3;
   localparam logic [3:0] S_SHDN    = 4'd4;
   localparam logic [3:0] S_UP_INIT = 4'd5;
   localparam logic [3:0] S_SHUP    = 4'd6;
   localparam logic [3:0] S_PLACE   = 4'd7;
   localparam logic [3:0] S_RESP    = 4'd8;

   logic [3:0]                   state_ff, state_in;
   logic                         phase_ff, phase_in;  // second search of a modify
   logic [sst_pkg::STATUS_W-1:0] code_ff, code_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_free;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      code_in      = code_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      cmd.use_new  = phase_ff;
      cmd.code     = code_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               phase_in = 1'b0;
               state_in = S_SRCH;
            end
         end
         // window empty: act on the lower bound, else probe the midpoint
         S_SRCH: begin
            if (!stat.srch_done) begin
               state_in = S_CMP;
            end else if (phase_ff) begin
               if (stat.hit) begin
                  code_in  = sst_pkg::ST_MISS;
                  state_in = S_RESP;
               end else begin
                  cmd.save_q = 1'b1;
                  state_in   = S_DN_INIT;
               end
            end else begin
               cmd.save_pos = 1'b1;
               unique case (stat.op)
                  sst_pkg::OP_INSERT: begin
                     priority if (stat.hit) begin
                        code_in  = sst_pkg::ST_MISS;
                        state_in = S_RESP;
                     end else if (stat.full) begin
                        code_in  = sst_pkg::ST_FULL;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_UP_INIT;
                     end
                  end
                  sst_pkg::OP_DELETE: begin
                     if (stat.hit) begin
                        state_in = S_DN_INIT;
                     end else begin
                        code_in  = sst_pkg::ST_MISS;
                        state_in = S_RESP;
                     end
                  end
                  sst_pkg::OP_MODIFY: begin
                     if (stat.hit) begin
                        cmd.srch_init = 1'b1;
                        phase_in      = 1'b1;
                        state_in      = S_SRCH;
                     end else begin
                        code_in  = sst_pkg::ST_MISS;
                        state_in = S_RESP;
                     end
                  end
                  sst_pkg::OP_QUERY: begin
                     code_in  = stat.hit ? sst_pkg::ST_OK : sst_pkg::ST_MISS;
                     state_in = S_RESP;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_CMP: begin
            cmd.srch_cmp = 1'b1;
            state_in     = S_SRCH;
         end
         S_DN_INIT: begin
            cmd.dn_init = 1'b1;
            state_in    = S_SHDN;
         end
         // close the gap; a modify goes on to open one for the new key
         S_SHDN: begin
            cmd.shift_dn = 1'b1;
            if (!stat.dn_more) begin
               cmd.cnt_dec = 1'b1;
               if (phase_ff) begin
                  state_in = S_UP_INIT;
               end else begin
                  code_in  = sst_pkg::ST_OK;
                  state_in = S_RESP;
               end
            end
         end
         S_UP_INIT: begin
            cmd.up_init   = 1'b1;
            cmd.set_pos_q = phase_ff;
            state_in      = S_SHUP;
         end
         S_SHUP: begin
            cmd.shift_up = 1'b1;
            if (!stat.up_more) begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            cmd.place   = 1'b1;
            cmd.cnt_inc = 1'b1;
            code_in     = sst_pkg::ST_OK;
            state_in    = S_RESP;
         end
         // hand the result to the output register once it is free
         S_RESP: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
   end

endmodule

[hw/rtl/sorted_set_table.sv]
`timescale 1ns / 1ps

// Sorted set of distinct signed 32-bit keys held in ascending order.
// Request channel (req_): req_tuser carries the operation (insert, delete,
// modify, query), req_tdata the key and, for modify, the replacement key.
// Result channel (rsp_): one item per request; rsp_tuser is the status
// (success, key absent or duplicate, store full), rsp_tdata the slot and
// the number of keys held afterwards.
// A search makes at most ceil(log2(n+1)) probes with n keys held. A probe
// puts the midpoint address to the store, then compares the registered
// read data; shifting moves one key a cycle through the single read and
// write port of the store.
// One request is worked on at a time; the next is taken once the result
// sits in the output register, which holds it while rsp_tready is low.
// A result waiting there stalls only the finish of the following request.
// Reset empties the set at once; the store needs no clearing.
module sorted_set_table #(
   parameter int unsigned CAPACITY = sst_pkg::CAPACITY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [sst_pkg::REQ_DATA_W-1:0]    req_tdata,  // key, new_key
   input  logic [sst_pkg::OP_W-1:0]          req_tuser,  // operation
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [sst_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // position, entries, zero pad
   output logic [sst_pkg::STATUS_W-1:0]      rsp_tuser   // status
);

   localparam int unsigned KW  = sst_pkg::KEY_W;
   localparam int unsigned PAD = sst_pkg::RSP_DATA_W - sst_pkg::POS_W - sst_pkg::ENT_W;

   sst_pkg::sst_cmd_type      cmd;
   sst_pkg::sst_stat_type     stat;
   logic [sst_pkg::POS_W-1:0] position;
   logic [sst_pkg::ENT_W-1:0] entries;

   sst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   sst_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .req_op       (req_tuser),
      .req_key      (req_tdata[KW-1:0]),
      .req_new_key  (req_tdata[2*KW-1:KW]),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_status   (rsp_tuser),
      .rsp_position (position),
      .rsp_entries  (entries)
   );

   assign rsp_tdata = {{PAD{1'b0}}, entries, position};

endmodule

[hw/rtl/sst_checker.sv]
`timescale 1ns / 1ps

module sst_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [sst_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [sst_pkg::STATUS_W-1:0]   rsp_tuser
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   // no result item straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result item valid after reset");

   // status is one of the three codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == sst_pkg::ST_OK || rsp_tuser == sst_pkg::ST_MISS ||
                     rsp_tuser == sst_pkg::ST_FULL)
      else $error("unknown status code");

   // a failed request reports slot zero
   a_fail_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != sst_pkg::ST_OK |-> rsp_tdata[sst_pkg::POS_W-1:0] == '0)
      else $error("failed request with non-zero slot");

endmodule

bind sorted_set_table sst_checker u_sst_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[sim/sorted_set_table_test.sv]
`timescale 1ns / 1ps

module sorted_set_table_test;

   localparam int unsigned CAP          = sst_pkg::CAPACITY_DEF;
   localparam int unsigned RANDOM_ITEMS = 1030;
   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int unsigned DRAIN_CYCLES = 200;

   localparam logic signed [sst_pkg::KEY_W-1:0] KEY_MIN = 32'h8000_0000;
   localparam logic signed [sst_pkg::KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;
   localparam logic signed [sst_pkg::KEY_W-1:0] KEY_NEG = 32'hFFFF_FFFF;

   // one result item, as the block reports it
   typedef struct packed {
      logic [sst_pkg::STATUS_W-1:0] status;
      logic [sst_pkg::POS_W-1:0]    position;
      logic [sst_pkg::ENT_W-1:0]    entries;
   } outcome_type;

   // directed request; the result is typed in where it is obvious
   typedef struct packed {
      logic [sst_pkg::OP_W-1:0]  op;
      logic [sst_pkg::KEY_W-1:0] key;
      logic [sst_pkg::KEY_W-1:0] new_key;
      bit                        typed;
      outcome_type               outcome;
   } plan_row_type;

   // flavour of the random requests: fill up, drain, or anything goes
   typedef enum logic [1:0] {MIX_GROW, MIX_SHRINK, MIX_CHURN} mix_type;

   localparam int unsigned PLAN_ROWS = 24;
   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      // empty set: every request misses
      '{sst_pkg::OP_QUERY,  32'h0000_0000, 32'h0000_0000, 1'b1, '{sst_pkg::ST_MISS, 6'd0, 7'd0}},
      '{sst_pkg::OP_DELETE, KEY_MIN,       KEY_NEG,       1'b1, '{sst_pkg::ST_MISS, 6'd0, 7'd0}},
      '{sst_pkg::OP_MODIFY, 32'h0000_0001, 32'h0000_0002, 1'b1, '{sst_pkg::ST_MISS, 6'd0, 7'd0}},
      // extremes and zero, placed in order
      '{sst_pkg::OP_INSERT, KEY_MAX,       KEY_NEG,       1'b1, '{sst_pkg::ST_OK,   6'd0, 7'd1}},
      '{sst_pkg::OP_INSERT, KEY_MIN,       32'h0000_0000, 1'b1, '{sst_pkg::ST_OK,   6'd0, 7'd2}},
      '{sst_pkg::OP_INSERT, 32'h0000_0000, KEY_NEG,       1'b1, '{sst_pkg::ST_OK,   6'd1, 7'd3}},
      '{sst_pkg::OP_INSERT, KEY_NEG,       32'h0000_0000, 1'b1, '{sst_pkg::ST_OK,   6'd1, 7'd4}},
      // duplicate insert, then queries of the extremes
      '{sst_pkg::OP_INSERT, 32'h0000_0000, KEY_NEG,       1'b1, '{sst_pkg::ST_MISS, 6'd0, 7'd4}},
      '{sst_pkg::OP_QUERY,  KEY_MAX,       32'h0000_0000, 1'b1, '{sst_pkg::ST_OK,   6'd3, 7'd4}},
      '{sst_pkg::OP_QUERY,  KEY_MIN,       KEY_NEG,       1'b1, '{sst_pkg::ST_OK,   6'd0, 7'd4}},
      // modify refusals: equal keys, new key held, old key absent; then one that succeeds
      '{sst_pkg::OP_MODIFY, KEY_NEG,       KEY_NEG,       1'b1, '{sst_pkg::ST_MISS, 6'd0, 7'd4}},
      '{sst_pkg::OP_MODIFY, 32'h0000_0000, KEY_MAX,       1'b1, '{sst_pkg::ST_MISS, 6'd0, 7'd4}},
      '{sst_pkg::OP_MODIFY, 32'h0000_0007, 32'h0000_0008, 1'b1, '{sst_pkg::ST_MISS, 6'd0, 7'd4}},
      '{sst_pkg::OP_MODIFY, 32'h0000_0000, 32'h0000_0005, 1'b1, '{sst_pkg::ST_OK,   6'd2, 7'd4}},
      // modify across the whole order, then queries, deletes and inserts
      '{sst_pkg::OP_MODIFY, KEY_MIN,       32'h7FFF_FFFE, 1'b0, '0},
      '{sst_pkg::OP_MODIFY, KEY_MAX,       KEY_MIN,       1'b0, '0},
      '{sst_pkg::OP_QUERY,  32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
      '{sst_pkg::OP_DELETE, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0},
      '{sst_pkg::OP_DELETE, KEY_NEG,       32'h0000_0000, 1'b0, '0},
      '{sst_pkg::OP_INSERT, 32'hAAAA_AAAA, KEY_NEG,       1'b0, '0},
      '{sst_pkg::OP_INSERT, 32'h5555_5555, 32'h0000_0000, 1'b0, '0},
      '{sst_pkg::OP_DELETE, KEY_MIN,       KEY_NEG,       1'b0, '0},
      '{sst_pkg::OP_DELETE, 32'h7FFF_FFFE, 32'h0000_0000, 1'b0, '0},
      '{sst_pkg::OP_QUERY,  32'h0000_0005, KEY_NEG,       1'b0, '0}
   };

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [sst_pkg::REQ_DATA_W-1:0] req_tdata  = '0;   // key, new_key
   logic [sst_pkg::OP_W-1:0]       req_tuser  = '0;   // operation
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [sst_pkg::RSP_DATA_W-1:0] rsp_tdata;         // position, entries, zero pad
   logic [sst_pkg::STATUS_W-1:0]   rsp_tuser;         // status

   // set held by the predictor, ascending
   logic signed [sst_pkg::KEY_W-1:0] set_keys [CAP];
   int unsigned                      set_size = 0;

   outcome_type pending_results [$];
   int unsigned mismatches = 0;
   int unsigned cycles     = 0;
   bit          calm       = 1'b0;

   sorted_set_table #(.CAPACITY(CAP)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
   end

   // random pause on either side, none during the calm stretch
   function automatic bit take_break();
      return !calm && ($urandom_range(0, 99) < 14);
   endfunction

   // first slot whose key is not below k
   function automatic int unsigned first_not_below(
      input logic signed [sst_pkg::KEY_W-1:0] k);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lo = 0;
      hi = set_size;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (set_keys[mid] < k) lo = mid + 1;
         else hi = mid;
      end
      return lo;
   endfunction

   function automatic bit key_held(input logic signed [sst_pkg::KEY_W-1:0] k,
                                   output int unsigned slot);
      slot = first_not_below(k);
      return (slot < set_size) && (set_keys[slot] == k);
   endfunction

   function automatic void open_slot(input int unsigned p,
                                     input logic signed [sst_pkg::KEY_W-1:0] k);
      for (int unsigned j = set_size; j > p; j--) set_keys[j] = set_keys[j-1];
      set_keys[p] = k;
      set_size++;
   endfunction

   function automatic void close_slot(input int unsigned p);
      for (int unsigned j = p; j + 1 < set_size; j++) set_keys[j] = set_keys[j+1];
      set_size--;
   endfunction

   // carries out one request on the predicted set and gives its result
   function automatic outcome_type apply_request(input logic [sst_pkg::OP_W-1:0] op,
                                                 input logic signed [sst_pkg::KEY_W-1:0] k,
                                                 input logic signed [sst_pkg::KEY_W-1:0] nk);
      outcome_type r;
      int unsigned p;
      int unsigned q;
      r.status   = sst_pkg::ST_MISS;
      r.position = '0;
      case (op)
         sst_pkg::OP_INSERT: begin
            if (!key_held(k, p)) begin
               if (set_size >= CAP) begin
                  r.status = sst_pkg::ST_FULL;
               end else begin
                  open_slot(p, k);
                  r.status   = sst_pkg::ST_OK;
                  r.position = p[sst_pkg::POS_W-1:0];
               end
            end
         end
         sst_pkg::OP_DELETE: begin
            if (key_held(k, p)) begin
               close_slot(p);
               r.status   = sst_pkg::ST_OK;
               r.position = p[sst_pkg::POS_W-1:0];
            end
         end
         sst_pkg::OP_MODIFY: begin
            if (key_held(k, p)) begin
               if (!key_held(nk, q)) begin
                  close_slot(p);
                  q = first_not_below(nk);
                  open_slot(q, nk);
                  r.status   = sst_pkg::ST_OK;
                  r.position = q[sst_pkg::POS_W-1:0];
               end
            end
         end
         default: begin
            if (key_held(k, p)) begin
               r.status   = sst_pkg::ST_OK;
               r.position = p[sst_pkg::POS_W-1:0];
            end
         end
      endcase
      r.entries = set_size[sst_pkg::ENT_W-1:0];
      return r;
   endfunction

   // a held key, or a fresh one with the extremes now and then
   function automatic logic signed [sst_pkg::KEY_W-1:0] pick_key(input bit from_set);
      int unsigned roll;
      roll = $urandom_range(0, 15);
      if (from_set && set_size != 0) return set_keys[$urandom_range(0, set_size - 1)];
      case (roll)
         0:       return KEY_MIN;
         1:       return KEY_MAX;
         2:       return '0;
         3:       return KEY_NEG;
         default: return $urandom;
      endcase
   endfunction

   function automatic void choose_request(input mix_type mix,
                                          output logic [sst_pkg::OP_W-1:0] op,
                                          output logic signed [sst_pkg::KEY_W-1:0] k,
                                          output logic signed [sst_pkg::KEY_W-1:0] nk);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_GROW:   op = roll < 65 ? sst_pkg::OP_INSERT : roll < 75 ? sst_pkg::OP_MODIFY :
                          roll < 88 ? sst_pkg::OP_QUERY : sst_pkg::OP_DELETE;
         MIX_SHRINK: op = roll < 65 ? sst_pkg::OP_DELETE : roll < 75 ? sst_pkg::OP_MODIFY :
                          roll < 88 ? sst_pkg::OP_QUERY : sst_pkg::OP_INSERT;
         default:    op = sst_pkg::OP_W'($urandom_range(0, 3));
      endcase
      if (op == sst_pkg::OP_INSERT) k = pick_key($urandom_range(0, 99) < 15);
      else k = pick_key($urandom_range(0, 99) < 80);
      // new key mostly fresh; sometimes held or equal to the old key
      roll = $urandom_range(0, 99);
      if (op != sst_pkg::OP_MODIFY) nk = $urandom;
      else if (roll < 5) nk = k;
      else nk = pick_key(roll < 25);
   endfunction

   // present one request and return once it is taken
   task automatic offer_request(input logic [sst_pkg::OP_W-1:0] op,
                                input logic [sst_pkg::KEY_W-1:0] k,
                                input logic [sst_pkg::KEY_W-1:0] nk);
      if (take_break()) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while (take_break());
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {nk, k};
      do @(posedge clock); while (!req_tready);
   endtask

   // result side: compare against the oldest expectation, then pick ready
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result item: status %0d position %0d entries %0d",
                   rsp_tuser, rsp_tdata[sst_pkg::POS_W-1:0],
                   rsp_tdata[sst_pkg::POS_W+sst_pkg::ENT_W-1:sst_pkg::POS_W]);
            mismatches <= mismatches + 1;
         end else begin
            automatic outcome_type want = pending_results.pop_front();
            automatic int unsigned bad = 0;
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               bad++;
            end
            if (rsp_tdata[sst_pkg::POS_W-1:0] !== want.position) begin
               $error("position: expected %0d, got %0d", want.position,
                      rsp_tdata[sst_pkg::POS_W-1:0]);
               bad++;
            end
            if (rsp_tdata[sst_pkg::POS_W+sst_pkg::ENT_W-1:sst_pkg::POS_W] !== want.entries)
            begin
               $error("entries: expected %0d, got %0d", want.entries,
                      rsp_tdata[sst_pkg::POS_W+sst_pkg::ENT_W-1:sst_pkg::POS_W]);
               bad++;
            end
            mismatches <= mismatches + bad;
         end
      end
      rsp_tready <= !take_break();
   end

   // watchdog
   initial begin
      while (cycles < CYCLE_LIMIT) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      logic [sst_pkg::OP_W-1:0]         op;
      logic signed [sst_pkg::KEY_W-1:0] k;
      logic signed [sst_pkg::KEY_W-1:0] nk;
      outcome_type                      got;
      mix_type                          mix;
      int unsigned                      sent;
      int unsigned                      phase_len;
      int unsigned                      at_limit;
      bit                               phase_done;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed part
      for (int unsigned row = 0; row < PLAN_ROWS; row++) begin
         offer_request(PLAN[row].op, PLAN[row].key, PLAN[row].new_key);
         got = apply_request(PLAN[row].op, PLAN[row].key, PLAN[row].new_key);
         pending_results.push_back(PLAN[row].typed ? PLAN[row].outcome : got);
      end

      // random part: fill towards full, drain towards empty, free mix, and round again
      mix       = MIX_GROW;
      sent      = 0;
      phase_len = 0;
      at_limit  = 0;
      while (sent < RANDOM_ITEMS) begin
         calm = (sent >= 450) && (sent < 600);
         choose_request(mix, op, k, nk);
         offer_request(op, k, nk);
         pending_results.push_back(apply_request(op, k, nk));
         sent++;
         phase_len++;
         case (mix)
            MIX_GROW: begin
               if (set_size == CAP) at_limit++;
               phase_done = (at_limit >= 25) || (phase_len >= 300);
            end
            MIX_SHRINK: begin
               if (set_size == 0) at_limit++;
               phase_done = (at_limit >= 8) || (phase_len >= 300);
            end
            default: phase_done = phase_len >= 80;
         endcase
         if (phase_done) begin
            mix       = mix == MIX_GROW ? MIX_SHRINK : mix == MIX_SHRINK ? MIX_CHURN : MIX_GROW;
            phase_len = 0;
            at_limit  = 0;
         end
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      // drain, then give any stray result time to show up
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/sst_pkg.sv
hw/rtl/sst_dpath.sv
hw/rtl/sst_ctrl.sv
hw/rtl/sorted_set_table.sv
hw/rtl/sst_checker.sv
sim/sorted_set_table_test.sv
